// ===== hdl/quaternion_rigid_point_transform_core_assert.svh =====
// Assertion macros used by the checker of the quaternion transform core.
`ifndef QUATERNION_RIGID_POINT_TRANSFORM_CORE_ASSERT_SVH
`define QUATERNION_RIGID_POINT_TRANSFORM_CORE_ASSERT_SVH

// Same-cycle implication, switched off while reset is held.
`define QRPT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define QRPT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/qrpt_pkg.sv =====
// Shared constants, codes, types and helpers of the quaternion transform core.
package qrpt_pkg;

    localparam int COORD_WIDTH    = 32;
    localparam int QUAT_FRAC_BITS = 14;
    localparam int CFG_IDX_W      = 3;
    // Register stages between the input word and the output register inclusive.
    localparam int PIPE_DEPTH     = 7;

    localparam logic [1:0] FUNC_PT_WORLD  = 2'd0;
    localparam logic [1:0] FUNC_VEC_WORLD = 2'd1;
    localparam logic [1:0] FUNC_PT_OBJ    = 2'd2;
    localparam logic [1:0] FUNC_VEC_OBJ   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_W   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_X   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_Y   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_Z   = 3'd6;

    typedef struct packed {
        logic       valid;
        logic [1:0] func;
    } t_stage;

    // Object modes rotate by the conjugate quaternion.
    function automatic logic f_to_object(logic [1:0] f);
        return (f == FUNC_PT_OBJ) || (f == FUNC_VEC_OBJ);
    endfunction

endpackage

// ===== hdl/qrpt_in_if.sv =====
// Input channel of the transform core: mode and coordinate triple.
interface qrpt_in_if #(
    parameter int COORD_WIDTH = qrpt_pkg::COORD_WIDTH
) ();
    logic                          valid;
    logic                          ready;
    logic [1:0]                    func;
    logic signed [COORD_WIDTH-1:0] in_x;
    logic signed [COORD_WIDTH-1:0] in_y;
    logic signed [COORD_WIDTH-1:0] in_z;

    modport source (output valid, func, in_x, in_y, in_z, input ready);
    modport sink   (input valid, func, in_x, in_y, in_z, output ready);
endinterface

// ===== hdl/qrpt_out_if.sv =====
// Output channel of the transform core: transformed triple and clamp flag.
interface qrpt_out_if #(
    parameter int COORD_WIDTH = qrpt_pkg::COORD_WIDTH
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] out_x;
    logic signed [COORD_WIDTH-1:0] out_y;
    logic signed [COORD_WIDTH-1:0] out_z;
    logic                          saturated;

    modport source (output valid, out_x, out_y, out_z, saturated, input ready);
    modport sink   (input valid, out_x, out_y, out_z, saturated, output ready);
endinterface

// ===== hdl/qrpt_cfg.sv =====
// Frame configuration registers: translation and rotation quaternion.
module qrpt_cfg #(
    parameter int COORD_WIDTH    = qrpt_pkg::COORD_WIDTH,
    parameter int QUAT_FRAC_BITS = qrpt_pkg::QUAT_FRAC_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [qrpt_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [((COORD_WIDTH > QUAT_FRAC_BITS + 2) ?
                   COORD_WIDTH : QUAT_FRAC_BITS + 2)-1:0] i_cfg_data,
    output logic signed [COORD_WIDTH-1:0]          o_off [3],
    output logic signed [QUAT_FRAC_BITS+1:0]       o_w,
    output logic signed [QUAT_FRAC_BITS+1:0]       o_u [3]
);
    localparam int CW = COORD_WIDTH;
    localparam int QW = QUAT_FRAC_BITS + 2;
    localparam logic signed [QW-1:0] W_ONE = QW'(1) << QUAT_FRAC_BITS;

    logic signed [CW-1:0] r_off [3];
    logic signed [QW-1:0] r_w;
    logic signed [QW-1:0] r_u [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off <= '{default: '0};
            r_w   <= W_ONE;
            r_u   <= '{default: '0};
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                qrpt_pkg::REG_OFFSET_X: r_off[0] <= i_cfg_data[CW-1:0];
                qrpt_pkg::REG_OFFSET_Y: r_off[1] <= i_cfg_data[CW-1:0];
                qrpt_pkg::REG_OFFSET_Z: r_off[2] <= i_cfg_data[CW-1:0];
                qrpt_pkg::REG_QUAT_W:   r_w      <= i_cfg_data[QW-1:0];
                qrpt_pkg::REG_QUAT_X:   r_u[0]   <= i_cfg_data[QW-1:0];
                qrpt_pkg::REG_QUAT_Y:   r_u[1]   <= i_cfg_data[QW-1:0];
                qrpt_pkg::REG_QUAT_Z:   r_u[2]   <= i_cfg_data[QW-1:0];
                default: ;
            endcase
        end
    end

    assign o_off = r_off;
    assign o_w   = r_w;
    assign o_u   = r_u;
endmodule

// ===== hdl/qrpt_cross.sv =====
// Front pipeline: offset removal, u x v products and the rounded cross term c.
module qrpt_cross #(
    parameter int COORD_WIDTH    = qrpt_pkg::COORD_WIDTH,
    parameter int QUAT_FRAC_BITS = qrpt_pkg::QUAT_FRAC_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  qrpt_pkg::t_stage                   i_ctl,
    output logic                               o_rdy,
    input  logic signed [COORD_WIDTH-1:0]      i_v [3],
    input  logic signed [COORD_WIDTH-1:0]      i_off [3],
    input  logic signed [QUAT_FRAC_BITS+1:0]   i_u [3],
    output qrpt_pkg::t_stage                   o_ctl,
    input  logic                               i_rdy,
    output logic signed [COORD_WIDTH:0]        o_d [3],
    output logic signed [COORD_WIDTH+5:0]      o_c [3]
);
    localparam int CW = COORD_WIDTH;
    localparam int F  = QUAT_FRAC_BITS;
    localparam int QW = F + 2;
    localparam int PW = CW + 1 + QW;
    localparam int XW = CW + QW + 4;
    localparam logic signed [XW-1:0] RND = XW'(1) << (F - 1);

    qrpt_pkg::t_stage     r_c1, r_c2, r_c3;
    logic signed [CW:0]   r_d1 [3];
    logic signed [CW:0]   r_d2 [3];
    logic signed [CW:0]   r_d3 [3];
    logic signed [PW-1:0] r_p2 [6];
    logic signed [CW+5:0] r_cc3 [3];
    logic signed [CW:0]   n_d1 [3];
    logic signed [XW-1:0] n_x3 [3];
    logic                 w_adv1, w_adv2, w_adv3;

    // A stage takes a new word when it is empty or its word moves on.
    assign w_adv3 = !r_c3.valid || i_rdy;
    assign w_adv2 = !r_c2.valid || w_adv3;
    assign w_adv1 = !r_c1.valid || w_adv2;
    assign o_rdy  = w_adv1;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (i_ctl.func == qrpt_pkg::FUNC_PT_OBJ) begin
                n_d1[i] = (CW+1)'(i_v[i]) - (CW+1)'(i_off[i]);
            end else begin
                n_d1[i] = (CW+1)'(i_v[i]);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_x3[i] = XW'(r_p2[2*i]) - XW'(r_p2[2*i+1]);
            if (qrpt_pkg::f_to_object(r_c2.func)) begin
                n_x3[i] = -n_x3[i];
            end
            n_x3[i] = n_x3[i] + RND;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1 <= '0;
            r_c2 <= '0;
            r_c3 <= '0;
        end else begin
            if (w_adv1) begin
                r_c1 <= i_ctl;
            end
            if (w_adv2) begin
                r_c2 <= r_c1;
            end
            if (w_adv3) begin
                r_c3 <= r_c2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r_d1 <= n_d1;
        end
        if (w_adv2) begin
            r_d2    <= r_d1;
            r_p2[0] <= i_u[1] * r_d1[2];
            r_p2[1] <= i_u[2] * r_d1[1];
            r_p2[2] <= i_u[2] * r_d1[0];
            r_p2[3] <= i_u[0] * r_d1[2];
            r_p2[4] <= i_u[0] * r_d1[1];
            r_p2[5] <= i_u[1] * r_d1[0];
        end
        if (w_adv3) begin
            r_d3 <= r_d2;
            for (int i = 0; i < 3; i++) begin
                r_cc3[i] <= n_x3[i][XW-1:F];
            end
        end
    end

    assign o_ctl = r_c3;
    assign o_d   = r_d3;
    assign o_c   = r_cc3;
endmodule

// ===== hdl/qrpt_rot.sv =====
// Back pipeline: w*c and u x c products, rounding and the final offset add.
module qrpt_rot #(
    parameter int COORD_WIDTH    = qrpt_pkg::COORD_WIDTH,
    parameter int QUAT_FRAC_BITS = qrpt_pkg::QUAT_FRAC_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  qrpt_pkg::t_stage                   i_ctl,
    output logic                               o_rdy,
    input  logic signed [COORD_WIDTH:0]        i_d [3],
    input  logic signed [COORD_WIDTH+5:0]      i_c [3],
    input  logic signed [COORD_WIDTH-1:0]      i_off [3],
    input  logic signed [QUAT_FRAC_BITS+1:0]   i_w,
    input  logic signed [QUAT_FRAC_BITS+1:0]   i_u [3],
    output qrpt_pkg::t_stage                   o_ctl,
    input  logic                               i_rdy,
    output logic signed [COORD_WIDTH+13:0]     o_t [3]
);
    localparam int CW = COORD_WIDTH;
    localparam int F  = QUAT_FRAC_BITS;
    localparam int QW = F + 2;
    localparam int MW = QW + CW + 6;
    localparam int SW = MW + 3;
    localparam int TW = CW + 14;
    localparam int RW = SW - F + 1;
    localparam logic signed [SW-1:0] RND = SW'(1) << (F - 2);

    qrpt_pkg::t_stage     r_c4, r_c5, r_c6;
    logic signed [CW:0]   r_d4 [3];
    logic signed [CW:0]   r_d5 [3];
    logic signed [MW-1:0] r_m4 [3];
    logic signed [MW-1:0] r_a4 [3];
    logic signed [MW-1:0] r_b4 [3];
    logic signed [SW-1:0] r_s5 [3];
    logic signed [TW-1:0] r_t6 [3];
    logic signed [SW-1:0] n_k5 [3];
    logic signed [SW-1:0] n_r6 [3];
    logic signed [RW-1:0] n_q6 [3];
    logic signed [TW-1:0] n_t6 [3];
    logic                 w_adv4, w_adv5, w_adv6;

    assign w_adv6 = !r_c6.valid || i_rdy;
    assign w_adv5 = !r_c5.valid || w_adv6;
    assign w_adv4 = !r_c4.valid || w_adv5;
    assign o_rdy  = w_adv4;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            // The conjugate flips the sign of u, hence of u x c.
            n_k5[i] = SW'(r_a4[i]) - SW'(r_b4[i]);
            if (qrpt_pkg::f_to_object(r_c4.func)) begin
                n_k5[i] = -n_k5[i];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_r6[i] = r_s5[i] + RND;
            n_q6[i] = n_r6[i][SW-1:F-1];
            n_t6[i] = TW'(r_d5[i]) + TW'(n_q6[i]);
            if (r_c5.func == qrpt_pkg::FUNC_PT_WORLD) begin
                n_t6[i] = n_t6[i] + TW'(i_off[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c4 <= '0;
            r_c5 <= '0;
            r_c6 <= '0;
        end else begin
            if (w_adv4) begin
                r_c4 <= i_ctl;
            end
            if (w_adv5) begin
                r_c5 <= r_c4;
            end
            if (w_adv6) begin
                r_c6 <= r_c5;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv4) begin
            r_d4 <= i_d;
            for (int i = 0; i < 3; i++) begin
                r_m4[i] <= i_w * i_c[i];
            end
            r_a4[0] <= i_u[1] * i_c[2];
            r_b4[0] <= i_u[2] * i_c[1];
            r_a4[1] <= i_u[2] * i_c[0];
            r_b4[1] <= i_u[0] * i_c[2];
            r_a4[2] <= i_u[0] * i_c[1];
            r_b4[2] <= i_u[1] * i_c[0];
        end
        if (w_adv5) begin
            r_d5 <= r_d4;
            for (int i = 0; i < 3; i++) begin
                r_s5[i] <= SW'(r_m4[i]) + n_k5[i];
            end
        end
        if (w_adv6) begin
            r_t6 <= n_t6;
        end
    end

    assign o_ctl = r_c6;
    assign o_t   = r_t6;
endmodule

// ===== hdl/qrpt_sat.sv =====
// Output register with clamping to the coordinate range.
module qrpt_sat #(
    parameter int COORD_WIDTH = qrpt_pkg::COORD_WIDTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  qrpt_pkg::t_stage                   i_ctl,
    output logic                               o_rdy,
    input  logic signed [COORD_WIDTH+13:0]     i_t [3],
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [COORD_WIDTH-1:0]      o_out [3],
    output logic                               o_sat
);
    localparam int CW = COORD_WIDTH;
    localparam int TW = CW + 14;
    localparam logic signed [TW-1:0] HI = {{(TW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [TW-1:0] LO = ~HI;

    logic                 r_valid;
    logic signed [CW-1:0] r_out [3];
    logic                 r_sat;
    logic signed [CW-1:0] n_out [3];
    logic                 n_sat;
    logic                 w_adv;

    assign w_adv = !r_valid || i_ready;
    assign o_rdy = w_adv;

    always_comb begin
        n_sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if (i_t[i] > HI) begin
                n_out[i] = HI[CW-1:0];
                n_sat    = 1'b1;
            end else if (i_t[i] < LO) begin
                n_out[i] = LO[CW-1:0];
                n_sat    = 1'b1;
            end else begin
                n_out[i] = i_t[i][CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_adv) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
            r_sat <= n_sat;
        end
    end

    assign o_valid = r_valid;
    assign o_out   = r_out;
    assign o_sat   = r_sat;
endmodule

// ===== hdl/quaternion_rigid_point_transform_core.sv =====
// Top level of the quaternion rigid-frame point and vector transform core.
//
//   channel    dir  handshake            word
//   i_pt       in   valid / ready        func, in_x, in_y, in_z
//   o_res      out  valid / ready        out_x, out_y, out_z, saturated
//   i_cfg_*    in   write enable only    register index, data
//
// Seven register stages: offset removal, u x v products, rounded c, w*c and u x c
// products, sum, rounding with offset add, clamp into the output register.
// One word enters per cycle while i_pt.ready is high; the multiplier stages set the clock.
// Every stage holds its word while the next one is stalled, so empty stages still fill
// while the output waits. Reset clears all valid bits and restores the identity frame.
module quaternion_rigid_point_transform_core #(
    parameter int COORD_WIDTH    = qrpt_pkg::COORD_WIDTH,
    parameter int QUAT_FRAC_BITS = qrpt_pkg::QUAT_FRAC_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    qrpt_in_if.sink                                i_pt,
    qrpt_out_if.source                             o_res,
    input  logic                                   i_cfg_we,
    input  logic [qrpt_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [((COORD_WIDTH > QUAT_FRAC_BITS + 2) ?
                   COORD_WIDTH : QUAT_FRAC_BITS + 2)-1:0] i_cfg_data
);
    localparam int CW = COORD_WIDTH;
    localparam int QW = QUAT_FRAC_BITS + 2;

    logic signed [CW-1:0]  w_off [3];
    logic signed [QW-1:0]  w_w;
    logic signed [QW-1:0]  w_u [3];
    logic signed [CW-1:0]  w_v [3];
    logic signed [CW:0]    w_d [3];
    logic signed [CW+5:0]  w_c [3];
    logic signed [CW+13:0] w_t [3];
    logic signed [CW-1:0]  w_out [3];
    qrpt_pkg::t_stage      w_ctl_in, w_ctl_a, w_ctl_b;
    logic                  w_rdy_a, w_rdy_b, w_rdy_s;

    assign w_ctl_in = '{valid: i_pt.valid, func: i_pt.func};
    assign w_v      = '{i_pt.in_x, i_pt.in_y, i_pt.in_z};
    assign i_pt.ready = w_rdy_a;

    qrpt_cfg #(
        .COORD_WIDTH    (COORD_WIDTH),
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_off      (w_off),
        .o_w        (w_w),
        .o_u        (w_u)
    );

    qrpt_cross #(
        .COORD_WIDTH    (COORD_WIDTH),
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
    ) u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_in),
        .o_rdy   (w_rdy_a),
        .i_v     (w_v),
        .i_off   (w_off),
        .i_u     (w_u),
        .o_ctl   (w_ctl_a),
        .i_rdy   (w_rdy_b),
        .o_d     (w_d),
        .o_c     (w_c)
    );

    qrpt_rot #(
        .COORD_WIDTH    (COORD_WIDTH),
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
    ) u_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_a),
        .o_rdy   (w_rdy_b),
        .i_d     (w_d),
        .i_c     (w_c),
        .i_off   (w_off),
        .i_w     (w_w),
        .i_u     (w_u),
        .o_ctl   (w_ctl_b),
        .i_rdy   (w_rdy_s),
        .o_t     (w_t)
    );

    qrpt_sat #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_sat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_b),
        .o_rdy   (w_rdy_s),
        .i_t     (w_t),
        .o_valid (o_res.valid),
        .i_ready (o_res.ready),
        .o_out   (w_out),
        .o_sat   (o_res.saturated)
    );

    assign o_res.out_x = w_out[0];
    assign o_res.out_y = w_out[1];
    assign o_res.out_z = w_out[2];
endmodule

// ===== hdl/qrpt_checker.sv =====
// Port-level checker of the transform core and its bind to the top level.
`include "quaternion_rigid_point_transform_core_assert.svh"

module qrpt_checker #(
    parameter int COORD_WIDTH = qrpt_pkg::COORD_WIDTH
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic signed [COORD_WIDTH-1:0] i_out_x,
    input logic signed [COORD_WIDTH-1:0] i_out_y,
    input logic signed [COORD_WIDTH-1:0] i_out_z,
    input logic                          i_out_sat
);
    localparam int CNT_W = $clog2(qrpt_pkg::PIPE_DEPTH + 1);
    localparam logic signed [COORD_WIDTH-1:0] HI = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] LO = ~HI;

    logic [CNT_W-1:0] r_inflight;
    logic             w_in_acc, w_out_acc;

    assign w_in_acc  = i_in_valid && i_in_ready;
    assign w_out_acc = i_out_valid && i_out_ready;

    // Words accepted at the input and not yet delivered at the output.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else if (w_in_acc && !w_out_acc) begin
            r_inflight <= r_inflight + CNT_W'(1);
        end else if (w_out_acc && !w_in_acc) begin
            r_inflight <= r_inflight - CNT_W'(1);
        end
    end

    `QRPT_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_out_x) && $stable(i_out_y) && $stable(i_out_z) && $stable(i_out_sat),
        "stalled result word changed or vanished")
    `QRPT_ASSERT_IMP(a_depth, i_clk, i_rst_n, 1'b1,
        r_inflight <= CNT_W'(qrpt_pkg::PIPE_DEPTH), "more words in flight than stages")
    `QRPT_ASSERT_IMP(a_no_orphan, i_clk, i_rst_n, i_out_valid,
        r_inflight != '0, "result word offered with no input word in flight")
    `QRPT_ASSERT_IMP(a_sat_flag, i_clk, i_rst_n, i_out_valid && i_out_sat,
        i_out_x == HI || i_out_x == LO || i_out_y == HI || i_out_y == LO ||
        i_out_z == HI || i_out_z == LO, "clamp flag set without a clamped component")
endmodule

bind quaternion_rigid_point_transform_core qrpt_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_qrpt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pt.valid),
    .i_in_ready  (i_pt.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_x     (o_res.out_x),
    .i_out_y     (o_res.out_y),
    .i_out_z     (o_res.out_z),
    .i_out_sat   (o_res.saturated)
);

// ===== tb/sv/qrpt_transform_checker.sv =====
`timescale 1ns / 1ps
// Checker for the quaternion transform core: frame model, queue of expected results, compare.
module qrpt_transform_checker
    import qrpt_pkg::*;
#(
    parameter int CFG_DATA_W = COORD_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    qrpt_in_if                    i_pt,
    qrpt_out_if                   i_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_words_in,
    output int                    o_words_out,
    output int                    o_clamped,
    output int                    o_fail_count
);

    localparam int     QW           = QUAT_FRAC_BITS + 2;
    localparam longint COORD_HI     = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
    localparam longint COORD_LO     = -COORD_HI - 1;
    localparam int     REPORT_LIMIT = 40;

    typedef struct packed {
        logic [1:0]                    func;
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic signed [COORD_WIDTH-1:0] z;
    } t_point_word;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic signed [COORD_WIDTH-1:0] z;
        logic                          clamped;
    } t_frame_result;

    logic signed [COORD_WIDTH-1:0] frame_offset [3];
    logic signed [QW-1:0]          frame_w;
    logic signed [QW-1:0]          frame_u [3];

    t_frame_result expected_q [$];
    t_frame_result want;
    t_point_word   seen;
    int            words_in   = 0;
    int            words_out  = 0;
    int            clamped    = 0;
    int            fail_count = 0;

    assign o_words_in   = words_in;
    assign o_words_out  = words_out;
    assign o_clamped    = clamped;
    assign o_fail_count = fail_count;

    // Shadow of the frame registers; bits above a register's width are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_offset[0] <= '0;
            frame_offset[1] <= '0;
            frame_offset[2] <= '0;
            frame_w         <= QW'(2 ** QUAT_FRAC_BITS);
            frame_u[0]      <= '0;
            frame_u[1]      <= '0;
            frame_u[2]      <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_OFFSET_X: frame_offset[0] <= i_cfg_data[COORD_WIDTH-1:0];
                REG_OFFSET_Y: frame_offset[1] <= i_cfg_data[COORD_WIDTH-1:0];
                REG_OFFSET_Z: frame_offset[2] <= i_cfg_data[COORD_WIDTH-1:0];
                REG_QUAT_W:   frame_w         <= i_cfg_data[QW-1:0];
                REG_QUAT_X:   frame_u[0]      <= i_cfg_data[QW-1:0];
                REG_QUAT_Y:   frame_u[1]      <= i_cfg_data[QW-1:0];
                REG_QUAT_Z:   frame_u[2]      <= i_cfg_data[QW-1:0];
                default: ;
            endcase
        end
    end

    // Rounds half toward plus infinity; the arithmetic shift floors.
    function automatic longint round_half_up(input longint x, input int s);
        return (x + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic t_frame_result transform_word(input t_point_word pw);
        longint        vec [3];
        longint        axis [3];
        longint        uxv [3];
        longint        uxc [3];
        longint        sum;
        longint        scal;
        logic          to_obj;
        logic          is_point;
        logic          clamp;
        logic [COORD_WIDTH-1:0] comp [3];
        t_frame_result outcome;
        to_obj   = (pw.func == FUNC_PT_OBJ) || (pw.func == FUNC_VEC_OBJ);
        is_point = (pw.func == FUNC_PT_WORLD) || (pw.func == FUNC_PT_OBJ);
        vec[0]   = longint'(signed'(pw.x));
        vec[1]   = longint'(signed'(pw.y));
        vec[2]   = longint'(signed'(pw.z));
        scal     = longint'(frame_w);
        clamp    = 1'b0;
        for (int i = 0; i < 3; i++) begin
            axis[i] = longint'(frame_u[i]);
            if (to_obj) begin
                // The conjugate only flips the axis; a point loses the offset first.
                axis[i] = -axis[i];
                if (is_point)
                    vec[i] = vec[i] - longint'(frame_offset[i]);
            end
        end
        uxv[0] = round_half_up(axis[1] * vec[2] - axis[2] * vec[1], QUAT_FRAC_BITS);
        uxv[1] = round_half_up(axis[2] * vec[0] - axis[0] * vec[2], QUAT_FRAC_BITS);
        uxv[2] = round_half_up(axis[0] * vec[1] - axis[1] * vec[0], QUAT_FRAC_BITS);
        uxc[0] = axis[1] * uxv[2] - axis[2] * uxv[1];
        uxc[1] = axis[2] * uxv[0] - axis[0] * uxv[2];
        uxc[2] = axis[0] * uxv[1] - axis[1] * uxv[0];
        for (int i = 0; i < 3; i++) begin
            sum = vec[i] + round_half_up(scal * uxv[i] + uxc[i], QUAT_FRAC_BITS - 1);
            if (!to_obj && is_point)
                sum = sum + longint'(frame_offset[i]);
            if (sum > COORD_HI) begin
                sum   = COORD_HI;
                clamp = 1'b1;
            end else if (sum < COORD_LO) begin
                sum   = COORD_LO;
                clamp = 1'b1;
            end
            comp[i] = COORD_WIDTH'(sum);
        end
        outcome.x       = comp[0];
        outcome.y       = comp[1];
        outcome.z       = comp[2];
        outcome.clamped = clamp;
        return outcome;
    endfunction

    task automatic report_mismatch(input string field, input logic [COORD_WIDTH-1:0] got,
                                   input logic [COORD_WIDTH-1:0] wanted);
        if (fail_count < REPORT_LIMIT)
            $display("[%0t] result %0d: %s is %h, expected %h",
                     $realtime, words_out, field, got, wanted);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_q.delete();
            words_in  <= 0;
            words_out <= 0;
            clamped   <= 0;
        end else begin
            if (i_pt.valid && i_pt.ready) begin
                seen.func = i_pt.func;
                seen.x    = i_pt.in_x;
                seen.y    = i_pt.in_y;
                seen.z    = i_pt.in_z;
                expected_q.push_back(transform_word(seen));
                words_in <= words_in + 1;
            end
            if (i_res.valid && i_res.ready) begin
                words_out <= words_out + 1;
                if (i_res.saturated === 1'b1)
                    clamped <= clamped + 1;
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected word, out_x", i_res.out_x, '0);
                end else begin
                    want = expected_q.pop_front();
                    if (i_res.out_x !== want.x)
                        report_mismatch("out_x", i_res.out_x, want.x);
                    if (i_res.out_y !== want.y)
                        report_mismatch("out_y", i_res.out_y, want.y);
                    if (i_res.out_z !== want.z)
                        report_mismatch("out_z", i_res.out_z, want.z);
                    if (i_res.saturated !== want.clamped)
                        report_mismatch("saturated", COORD_WIDTH'(i_res.saturated),
                                        COORD_WIDTH'(want.clamped));
                end
            end
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the quaternion transform core: clock, reset, stimulus and verdict.
module tb;
    import qrpt_pkg::*;

    localparam int CFG_DATA_W = (COORD_WIDTH > QUAT_FRAC_BITS + 2) ?
                                COORD_WIDTH : QUAT_FRAC_BITS + 2;
    localparam int QW            = QUAT_FRAC_BITS + 2;
    localparam int CLK_PERIOD    = 10;
    localparam int SEGMENT_WORDS = 46;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SEND_IDLE  [4] = '{0, 84, 0, 8};
    localparam int RECV_STALL [4] = '{0, 0, 84, 8};

    localparam logic [CFG_IDX_W-1:0]   REG_UNUSED   = CFG_IDX_W'(7);
    localparam logic [COORD_WIDTH-1:0] C_MAX        = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] C_MIN        = {1'b1, {(COORD_WIDTH - 1){1'b0}}};
    localparam logic [QW-1:0]          Q_ONE        = QW'(2 ** QUAT_FRAC_BITS);
    localparam logic [QW-1:0]          Q_NEG_ONE    = QW'(-(2 ** QUAT_FRAC_BITS));
    localparam logic [QW-1:0]          Q_MOST_NEG   = {1'b1, {(QW - 1){1'b0}}};
    localparam logic [QW-1:0]          Q_MOST_POS   = {1'b0, {(QW - 1){1'b1}}};
    localparam logic [QW-1:0]          Q_HALF_SQRT2 =
        QW'(int'(0.7071067811865476 * (2.0 ** QUAT_FRAC_BITS)));

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    send_idle_pct  = 0;
    int                    recv_stall_pct = 0;
    int                    cycle_count    = 0;
    int                    frames_written = 0;
    int                    words_in;
    int                    words_out;
    int                    clamped;
    int                    fail_count;

    qrpt_in_if  pt_if ();
    qrpt_out_if res_if ();

    quaternion_rigid_point_transform_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pt       (pt_if),
        .o_res      (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    qrpt_transform_checker #(
        .CFG_DATA_W (CFG_DATA_W)
    ) u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pt         (pt_if),
        .i_res        (res_if),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_words_in   (words_in),
        .o_words_out  (words_out),
        .o_clamped    (clamped),
        .o_fail_count (fail_count)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(negedge i_clk) begin
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Cycle limit reached with %0d results outstanding.", words_in - words_out);
            $display("quaternion_rigid_point_transform_core test failed");
            $finish;
        end
    end

    // Frame registers may only change once the pipeline has emptied.
    task automatic wait_idle();
        pt_if.valid = 1'b0;
        while (words_in != words_out)
            @(negedge i_clk);
        repeat (PIPE_DEPTH + 2) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        @(negedge i_clk);
    endtask

    task automatic write_frame(input logic [COORD_WIDTH-1:0] ox, input logic [COORD_WIDTH-1:0] oy,
                               input logic [COORD_WIDTH-1:0] oz, input logic [QW-1:0] qw,
                               input logic [QW-1:0] qx, input logic [QW-1:0] qy,
                               input logic [QW-1:0] qz);
        logic [CFG_DATA_W-1:0] noisy;
        logic [QW-1:0]         quat [4];
        quat = '{qw, qx, qy, qz};
        wait_idle();
        write_reg(REG_OFFSET_X, CFG_DATA_W'(ox));
        write_reg(REG_OFFSET_Y, CFG_DATA_W'(oy));
        write_reg(REG_OFFSET_Z, CFG_DATA_W'(oz));
        for (int i = 0; i < 4; i++) begin
            // Junk above the quaternion width must be ignored by the core.
            noisy           = CFG_DATA_W'($urandom);
            noisy[QW-1:0]   = quat[i];
            write_reg(REG_QUAT_W + CFG_IDX_W'(i), noisy);
        end
        // A write to the spare index must leave every register alone.
        write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        cfg_we = 1'b0;
        frames_written++;
    endtask

    // Offers one word, holding it until the core takes it.
    task automatic push_point(input logic [1:0] f, input logic [COORD_WIDTH-1:0] x,
                              input logic [COORD_WIDTH-1:0] y, input logic [COORD_WIDTH-1:0] z);
        while ($urandom_range(99) < send_idle_pct) begin
            pt_if.valid = 1'b0;
            @(negedge i_clk);
        end
        pt_if.valid = 1'b1;
        pt_if.func  = f;
        pt_if.in_x  = x;
        pt_if.in_y  = y;
        pt_if.in_z  = z;
        @(posedge i_clk);
        while (!pt_if.ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [COORD_WIDTH-1:0] random_coord();
        logic [COORD_WIDTH-1:0] wide;
        wide = COORD_WIDTH'({$urandom, $urandom});
        case ($urandom_range(9))
            0:       return C_MAX;
            1:       return C_MIN;
            2, 3, 4: return wide;
            default: return COORD_WIDTH'($signed(wide[21:0]));
        endcase
    endfunction

    task automatic random_frame();
        real           mix [4];
        real           norm;
        logic [QW-1:0] q [4];
        int            kind;
        int            axis;
        kind = $urandom_range(5);
        norm = 0.0;
        for (int i = 0; i < 4; i++) begin
            mix[i] = real'(int'($urandom_range(65535)) - 32768);
            norm   = norm + mix[i] * mix[i];
        end
        if (norm < 1.0) begin
            mix[0] = 1.0;
            norm   = 1.0;
        end
        norm = $sqrt(norm);
        for (int i = 0; i < 4; i++)
            q[i] = QW'(int'(mix[i] / norm * (2.0 ** QUAT_FRAC_BITS)));
        case (kind)
            4: begin
                // Raw codes: generally far from unit length.
                for (int i = 0; i < 4; i++)
                    q[i] = QW'($urandom);
            end
            5: begin
                axis = $urandom_range(1, 3);
                for (int i = 0; i < 4; i++)
                    q[i] = '0;
                if ($urandom_range(1) == 1) begin
                    q[axis] = ($urandom_range(1) == 1) ? Q_ONE : Q_NEG_ONE;
                end else begin
                    q[0]    = Q_HALF_SQRT2;
                    q[axis] = ($urandom_range(1) == 1) ? Q_HALF_SQRT2 : QW'(-Q_HALF_SQRT2);
                end
            end
            default: ;
        endcase
        if (kind == 3)
            write_frame('0, '0, '0, q[0], q[1], q[2], q[3]);
        else
            write_frame(random_coord(), random_coord(), random_coord(), q[0], q[1], q[2], q[3]);
    endtask

    initial begin
        cfg_we       = 1'b0;
        cfg_idx      = '0;
        cfg_data     = '0;
        pt_if.valid  = 1'b0;
        pt_if.func   = FUNC_PT_WORLD;
        pt_if.in_x   = '0;
        pt_if.in_y   = '0;
        pt_if.in_z   = '0;
        res_if.ready = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Identity frame straight out of reset, every mode at the range ends.
        push_point(FUNC_PT_WORLD, C_MAX, C_MIN, '0);
        push_point(FUNC_VEC_WORLD, C_MIN, C_MAX, COORD_WIDTH'(1));
        push_point(FUNC_PT_OBJ, C_MAX, C_MAX, C_MAX);
        push_point(FUNC_VEC_OBJ, C_MIN, C_MIN, C_MIN);
        push_point(FUNC_PT_WORLD, '0, '0, '0);

        // Quarter turn about z with extreme offsets, so intermediate sums leave the range.
        write_frame(C_MAX, C_MIN, COORD_WIDTH'(32'h0001_0000),
                    Q_HALF_SQRT2, '0, '0, Q_HALF_SQRT2);
        push_point(FUNC_PT_WORLD, C_MAX, C_MIN, COORD_WIDTH'(32'h1234_5678));
        push_point(FUNC_VEC_WORLD, C_MAX, C_MAX, C_MIN);
        push_point(FUNC_PT_OBJ, C_MIN, C_MAX, C_MAX);
        push_point(FUNC_VEC_OBJ, COORD_WIDTH'(32'h0001_0000), COORD_WIDTH'(32'hffff_0000), '0);

        // Most negative quaternion codes: not a rotation, and the conjugate must not wrap.
        write_frame(C_MIN, C_MAX, C_MIN, Q_MOST_NEG, Q_MOST_NEG, Q_MOST_NEG, Q_MOST_NEG);
        for (int f = 0; f < 4; f++)
            push_point(2'(f), C_MAX, C_MIN, C_MAX);

        // Largest positive codes for w and x, again far from unit length.
        write_frame(COORD_WIDTH'(32'h7fff_0000), '0, '1,
                    Q_MOST_POS, Q_MOST_POS, Q_MOST_NEG + QW'(1), '0);
        for (int f = 0; f < 4; f++)
            push_point(2'(f), random_coord(), random_coord(), random_coord());

        // Half turn about a negative x axis.
        write_frame(random_coord(), random_coord(), random_coord(), '0, Q_NEG_ONE, '0, '0);
        for (int f = 0; f < 4; f++)
            push_point(2'(f), random_coord(), random_coord(), random_coord());

        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct  = SEND_IDLE[phase];
            recv_stall_pct = RECV_STALL[phase];
            for (int seg = 0; seg < 3; seg++) begin
                random_frame();
                repeat (SEGMENT_WORDS)
                    push_point(2'($urandom_range(3)), random_coord(), random_coord(),
                               random_coord());
            end
        end

        pt_if.valid = 1'b0;
        while (words_in != words_out)
            @(negedge i_clk);
        repeat (4 * PIPE_DEPTH) @(negedge i_clk);

        $display("Sent %0d words in all four modes over %0d frame settings and four idling phases.",
                 words_in, frames_written);
        $display("Checked %0d results, %0d of them clamped, with %0d mismatches.",
                 words_out, clamped, fail_count);
        if (fail_count == 0) begin
            $display("quaternion_rigid_point_transform_core test passed");
        end else begin
            $display("quaternion_rigid_point_transform_core test failed");
        end
        $finish;
    end

endmodule
